FILE: sv/fbpa_pkg.sv
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
	localparam int SLOT_W = $clog2(MAX_BLOCKS);

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;
	localparam int BSIZE_W = 17;
	localparam int NBLK_W = 7;
	localparam int FREE_W = 7;

	localparam logic [BSIZE_W-1:0] MIN_BLOCK_BYTES = BSIZE_W'(4);
	localparam logic [BSIZE_W-1:0] MAX_BLOCK_BYTES = BSIZE_W'(65536);
	localparam logic [NBLK_W-1:0] MIN_BLOCKS = NBLK_W'(2);
	localparam logic [NBLK_W-1:0] MAX_BLOCKS_V = NBLK_W'(MAX_BLOCKS);

	localparam logic [ADDR_W-1:0] RST_BASE = 32'd4096;
	localparam logic [BSIZE_W-1:0] RST_BLOCK_BYTES = BSIZE_W'(64);
	localparam logic [NBLK_W-1:0] RST_POOL_BLOCKS = NBLK_W'(64);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_BASE = 2'd0,
		REG_BLOCK_BYTES = 2'd1,
		REG_POOL_BLOCKS = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_EMPTY = 3'd2,
		ST_NULL = 3'd3,
		ST_FULL = 3'd4,
		ST_MISMATCH = 3'd5
	} status_t;

	typedef struct packed {
		logic action;
		logic [SIZE_W-1:0] requested_size;
		logic [ADDR_W-1:0] returned_address;
		logic [SIZE_W-1:0] claimed_size;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [ADDR_W-1:0] block_address;
		logic [BSIZE_W-1:0] granted_size;
		logic [FREE_W-1:0] free_blocks;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stack_cmd_t;

endpackage

FILE: sv/fbpa_stack.sv
module fbpa_stack (
	input logic clk,
	input logic arst_n,
	input fbpa_pkg::stack_cmd_t cmd,
	input logic [fbpa_pkg::ADDR_W-1:0] push_data,
	output logic [fbpa_pkg::DEPTH_W-1:0] depth,
	output logic [fbpa_pkg::ADDR_W-1:0] top
);

	logic [fbpa_pkg::ADDR_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];
	logic [fbpa_pkg::DEPTH_W-1:0] depth_q;
	logic [fbpa_pkg::DEPTH_W-1:0] depth_next;
	logic [fbpa_pkg::DEPTH_W-1:0] rd_ptr;
	logic [fbpa_pkg::ADDR_W-1:0] top_q;

	always_comb begin
		priority if (cmd.clear) begin
			depth_next = '0;
		end else if (cmd.push) begin
			depth_next = depth_q + fbpa_pkg::DEPTH_W'(1);
		end else if (cmd.pop) begin
			depth_next = depth_q - fbpa_pkg::DEPTH_W'(1);
		end else begin
			depth_next = depth_q;
		end
	end

	// top_q always mirrors the entry just below the depth pointer
	assign rd_ptr = depth_next - fbpa_pkg::DEPTH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			depth_q <= depth_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[depth_q[fbpa_pkg::SLOT_W-1:0]] <= push_data;
			top_q <= push_data;
		end else begin
			top_q <= mem[rd_ptr[fbpa_pkg::SLOT_W-1:0]];
		end
	end

	assign depth = depth_q;
	assign top = top_q;

endmodule

FILE: sv/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator. Serves allocate and return requests: a request lands in
// an input register, is checked and applied against the free stack and fresh-block counter,
// and its result sits in an output register; a new request is taken every cycle while the
// result side keeps up. Returned blocks go on a 64-entry stack memory whose top is kept
// pre-read in a register; untouched blocks are handed out in address order from
// base + n*block_bytes. Writing any of the three APB registers (base 0x0, block size 0x4,
// block count 0x8) empties the pool state, making every block free again; do so only while
// no request is in flight.
module fixed_block_pool_allocator_core (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input fbpa_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output fbpa_pkg::rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [fbpa_pkg::PADDR_W-1:0] paddr,
	input logic [fbpa_pkg::PDATA_W-1:0] pwdata,
	output logic [fbpa_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	logic [fbpa_pkg::ADDR_W-1:0] base_q;
	logic [fbpa_pkg::BSIZE_W-1:0] bbytes_q;
	logic [fbpa_pkg::NBLK_W-1:0] nblk_q;
	logic cfg_wr;
	logic cfg_hit;
	fbpa_pkg::reg_idx_t cfg_idx;

	logic req_valid_s1;
	fbpa_pkg::req_t req_s1;
	logic advance;
	logic rsp_valid_q;
	fbpa_pkg::rsp_t rsp_q;
	fbpa_pkg::rsp_t rsp_next;

	logic [fbpa_pkg::NBLK_W-1:0] fresh_q;
	fbpa_pkg::stack_cmd_t cmd;
	logic [fbpa_pkg::DEPTH_W-1:0] depth;
	logic [fbpa_pkg::ADDR_W-1:0] top;

	logic [fbpa_pkg::BSIZE_W-1:0] bsize;
	logic [fbpa_pkg::NBLK_W-1:0] nblk;
	logic [fbpa_pkg::NBLK_W:0] free_now;
	logic [fbpa_pkg::NBLK_W:0] free_after;
	logic [fbpa_pkg::NBLK_W+fbpa_pkg::BSIZE_W-1:0] fresh_off;
	logic [fbpa_pkg::ADDR_W-1:0] fresh_addr;
	logic alloc_ok;
	logic free_ok;
	logic take_fresh;
	fbpa_pkg::status_t status;

	// config port
	assign pready = 1'b1;
	assign cfg_idx = fbpa_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_hit = cfg_wr && (cfg_idx != fbpa_pkg::REG_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= fbpa_pkg::RST_BASE;
			bbytes_q <= fbpa_pkg::RST_BLOCK_BYTES;
			nblk_q <= fbpa_pkg::RST_POOL_BLOCKS;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				fbpa_pkg::REG_BASE: base_q <= pwdata;
				fbpa_pkg::REG_BLOCK_BYTES: bbytes_q <= pwdata[fbpa_pkg::BSIZE_W-1:0];
				fbpa_pkg::REG_POOL_BLOCKS: nblk_q <= pwdata[fbpa_pkg::NBLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			fbpa_pkg::REG_BASE: prdata = base_q;
			fbpa_pkg::REG_BLOCK_BYTES: prdata = fbpa_pkg::PDATA_W'(bbytes_q);
			fbpa_pkg::REG_POOL_BLOCKS: prdata = fbpa_pkg::PDATA_W'(nblk_q);
			default: prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		priority if (bbytes_q < fbpa_pkg::MIN_BLOCK_BYTES) begin
			bsize = fbpa_pkg::MIN_BLOCK_BYTES;
		end else if (bbytes_q > fbpa_pkg::MAX_BLOCK_BYTES) begin
			bsize = fbpa_pkg::MAX_BLOCK_BYTES;
		end else begin
			bsize = bbytes_q;
		end
		priority if (nblk_q < fbpa_pkg::MIN_BLOCKS) begin
			nblk = fbpa_pkg::MIN_BLOCKS;
		end else if (nblk_q > fbpa_pkg::MAX_BLOCKS_V) begin
			nblk = fbpa_pkg::MAX_BLOCKS_V;
		end else begin
			nblk = nblk_q;
		end
	end

	// handshake
	assign advance = req_valid_s1 && !(rsp_valid_q && rsp_stall);
	assign req_stall = req_valid_s1 && rsp_valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// request evaluation
	assign free_now = (fbpa_pkg::NBLK_W+1)'(depth) + (fbpa_pkg::NBLK_W+1)'(nblk)
		- (fbpa_pkg::NBLK_W+1)'(fresh_q);
	assign fresh_off = (fbpa_pkg::NBLK_W+fbpa_pkg::BSIZE_W)'(fresh_q)
		* (fbpa_pkg::NBLK_W+fbpa_pkg::BSIZE_W)'(bsize);
	assign fresh_addr = base_q + fbpa_pkg::ADDR_W'(fresh_off);

	always_comb begin
		status = fbpa_pkg::ST_OK;
		alloc_ok = 1'b0;
		free_ok = 1'b0;
		if (req_s1.action == fbpa_pkg::ACT_ALLOC) begin
			priority if (req_s1.requested_size > fbpa_pkg::SIZE_W'(bsize)) begin
				status = fbpa_pkg::ST_TOO_LARGE;
			end else if (free_now == '0) begin
				status = fbpa_pkg::ST_EMPTY;
			end else begin
				alloc_ok = 1'b1;
			end
		end else begin
			priority if (req_s1.returned_address == '0) begin
				status = fbpa_pkg::ST_NULL;
			end else if (free_now >= (fbpa_pkg::NBLK_W+1)'(nblk)) begin
				status = fbpa_pkg::ST_FULL;
			end else if (req_s1.claimed_size != fbpa_pkg::SIZE_W'(bsize)) begin
				status = fbpa_pkg::ST_MISMATCH;
			end else begin
				free_ok = 1'b1;
			end
		end
	end

	assign take_fresh = alloc_ok && (depth == '0);

	always_comb begin
		priority if (alloc_ok) begin
			free_after = free_now - (fbpa_pkg::NBLK_W+1)'(1);
		end else if (free_ok) begin
			free_after = free_now + (fbpa_pkg::NBLK_W+1)'(1);
		end else begin
			free_after = free_now;
		end
	end

	always_comb begin
		rsp_next.status = status;
		rsp_next.block_address = '0;
		rsp_next.granted_size = '0;
		if (alloc_ok) begin
			rsp_next.block_address = take_fresh ? fresh_addr : top;
			rsp_next.granted_size = bsize;
		end
		rsp_next.free_blocks = free_after[fbpa_pkg::FREE_W-1:0];
	end

	always_comb begin
		cmd.clear = cfg_hit;
		cmd.push = advance && free_ok;
		cmd.pop = advance && alloc_ok && (depth != '0);
	end

	fbpa_stack u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.push_data(req_s1.returned_address),
		.depth(depth),
		.top(top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
		end else if (cfg_hit) begin
			fresh_q <= '0;
		end else if (advance && take_fresh) begin
			fresh_q <= fresh_q + fbpa_pkg::NBLK_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
